// ===== hdl/svalloc_pkg.sv =====
package svalloc_pkg;

   localparam int MODE_W     = 2;
   localparam int NOTE_W     = 7;
   localparam int VEL_W      = 7;
   localparam int POLY_W     = 4;
   localparam int SLOT_W     = 8;
   localparam int OUT_VOICE_W = 3;
   localparam int MASK_W     = 8;
   localparam int NUM_KEYS   = 128;
   localparam int KEY_GRP    = 8;
   localparam int GRP_POS_W  = 3;
   localparam int GRP_W      = 4;

   localparam logic [SLOT_W-1:0] VOICE_FREE = 8'hFF;
   localparam logic [POLY_W-1:0] POLY_RESET = 4'd8;

   // event codes on the request channel
   localparam logic [MODE_W-1:0] MODE_KEY_ON  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_KEY_OFF = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ALL_OFF = 2'd2;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_KEY_ON,
      OP_KEY_OFF,
      OP_ALL_OFF
   } op_type;

   typedef struct packed {
      logic load;
      logic voice_step;
      logic key_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   mono;
      logic   voice_last;
      logic   key_last;
      logic   key_hit;
      logic   out_free;
   } stat_type;

   typedef struct packed {
      logic                   assign_valid;
      logic [OUT_VOICE_W-1:0] assign_voice;
      logic [NOTE_W-1:0]      assign_note;
      logic [VEL_W-1:0]       assign_velocity;
      logic                   restart_voice;
      logic                   jump_pitch;
      logic                   dropped;
      logic [MASK_W-1:0]      released_mask;
   } rsp_type;

endpackage

// ===== hdl/svalloc_if.sv =====
interface svalloc_req_if import svalloc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [NOTE_W-1:0] note;
   logic [VEL_W-1:0]  velocity;

   modport source (output valid, mode, note, velocity, input ready);
   modport sink   (input valid, mode, note, velocity, output ready);
endinterface

interface svalloc_rsp_if import svalloc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   assign_valid;
   logic [OUT_VOICE_W-1:0] assign_voice;
   logic [NOTE_W-1:0]      assign_note;
   logic [VEL_W-1:0]       assign_velocity;
   logic                   restart_voice;
   logic                   jump_pitch;
   logic                   dropped;
   logic [MASK_W-1:0]      released_mask;

   modport source (output valid, assign_valid, assign_voice, assign_note, assign_velocity,
                   restart_voice, jump_pitch, dropped, released_mask, input ready);
   modport sink   (input valid, assign_valid, assign_voice, assign_note, assign_velocity,
                   restart_voice, jump_pitch, dropped, released_mask, output ready);
endinterface

// ===== hdl/svalloc_ctrl.sv =====
module svalloc_ctrl import svalloc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_VOICE,
      ST_KEY,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            case (stat.op)
               OP_KEY_ON:  state_in = stat.mono ? ST_FINISH : ST_VOICE;
               OP_KEY_OFF: state_in = ST_VOICE;
               OP_ALL_OFF: state_in = ST_VOICE;
               default:    state_in = ST_FINISH;
            endcase
         end
         ST_VOICE: begin
            if (stat.voice_last) begin
               state_in = (stat.op == OP_KEY_OFF && stat.mono) ? ST_KEY : ST_FINISH;
            end
         end
         ST_KEY: begin
            if (stat.key_hit || stat.key_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready      = ready_ff;
   assign cmd.load       = (state_ff == ST_IDLE) && req_valid && ready_ff;
   assign cmd.voice_step = (state_ff == ST_VOICE);
   assign cmd.key_step   = (state_ff == ST_KEY);
   assign cmd.commit     = (state_ff == ST_FINISH) && stat.out_free;

endmodule

// ===== hdl/svalloc_dp.sv =====
module svalloc_dp import svalloc_pkg::*; #(
   parameter int MAX_VOICES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic              csr_we,
   input  logic [POLY_W-1:0] csr_wdata,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [NOTE_W-1:0] req_note,
   input  logic [VEL_W-1:0]  req_velocity,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   localparam int VIW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int CW  = $clog2(MAX_VOICES + 1);

   logic [POLY_W-1:0]   poly_ff, poly_in;
   logic [SLOT_W-1:0]   voice_note_ff [MAX_VOICES];
   logic [SLOT_W-1:0]   voice_note_in [MAX_VOICES];
   logic [VEL_W-1:0]    voice_vel_ff [MAX_VOICES];
   logic [VEL_W-1:0]    voice_vel_in [MAX_VOICES];
   logic [NUM_KEYS-1:0] key_held_ff, key_held_in;
   op_type              op_ff, op_in;
   logic [NOTE_W-1:0]   note_ff, note_in;
   logic [VEL_W-1:0]    vel_ff, vel_in;
   logic [VIW-1:0]      vidx_ff, vidx_in;
   logic [GRP_W-1:0]    grp_ff, grp_in;
   logic                match_ff, match_in;
   logic                free_ff, free_in;
   logic [VIW-1:0]      match_idx_ff, match_idx_in;
   logic [VIW-1:0]      free_idx_ff, free_idx_in;
   logic [MASK_W-1:0]   mask_ff, mask_in;
   logic                hit_ff, hit_in;
   logic [NOTE_W-1:0]   hit_key_ff, hit_key_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [CW-1:0]        poly_eff;
   logic [CW-1:0]        scan_limit;
   logic                 mono;
   logic                 voice_last;
   op_type               req_op;
   logic [SLOT_W-1:0]    cur_note;
   logic                 cur_match;
   logic                 cur_free;
   logic [KEY_GRP-1:0]   grp_bits;
   logic                 grp_hit;
   logic [GRP_POS_W-1:0] hit_pos;
   logic                 out_free;
   rsp_type              res;
   logic                 wr_en;
   logic [VIW-1:0]       wr_idx;

   // effective voice count: zero acts as one, clamp at the voice count
   always_comb begin
      if (poly_ff == '0) begin
         poly_eff = CW'(1);
      end else if ({2'b00, poly_ff} > 6'(MAX_VOICES)) begin
         poly_eff = CW'(MAX_VOICES);
      end else begin
         poly_eff = CW'(poly_ff);
      end
   end

   assign mono       = (poly_eff == CW'(1));
   assign scan_limit = (op_ff == OP_KEY_ON) ? poly_eff : CW'(MAX_VOICES);
   assign voice_last = (vidx_ff == VIW'(scan_limit - CW'(1)));

   always_comb begin
      case (req_mode)
         MODE_KEY_ON:  req_op = (req_velocity != '0) ? OP_KEY_ON : OP_KEY_OFF;
         MODE_KEY_OFF: req_op = OP_KEY_OFF;
         MODE_ALL_OFF: req_op = OP_ALL_OFF;
         default:      req_op = OP_NONE;
      endcase
   end

   assign cur_note  = voice_note_ff[vidx_ff];
   assign cur_match = (cur_note == {1'b0, note_ff});
   assign cur_free  = (cur_note == VOICE_FREE);

   // one group of eight keys per cycle, from the top down
   assign grp_bits = key_held_ff[{grp_ff, 3'b000} +: KEY_GRP];
   assign grp_hit  = |grp_bits;

   always_comb begin
      hit_pos = '0;
      for (int b = 0; b < KEY_GRP; b++) begin
         if (grp_bits[b]) hit_pos = GRP_POS_W'(b);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // result of the finished event
   always_comb begin
      res               = '0;
      res.released_mask = mask_ff;
      wr_en             = 1'b0;
      wr_idx            = '0;
      case (op_ff)
         OP_KEY_ON: begin
            if (mono) begin
               wr_en          = 1'b1;
               res.jump_pitch = (voice_note_ff[0] == VOICE_FREE);
            end else if (match_ff) begin
               wr_en          = 1'b1;
               wr_idx         = match_idx_ff;
               res.jump_pitch = 1'b1;
            end else if (free_ff) begin
               wr_en          = 1'b1;
               wr_idx         = free_idx_ff;
               res.jump_pitch = 1'b1;
            end else begin
               res.dropped = 1'b1;
            end
            if (wr_en) begin
               res.assign_valid    = 1'b1;
               res.assign_voice    = OUT_VOICE_W'(wr_idx);
               res.assign_note     = note_ff;
               res.assign_velocity = vel_ff;
               res.restart_voice   = 1'b1;
            end
         end
         OP_KEY_OFF: begin
            if (hit_ff) begin
               res.assign_valid    = 1'b1;
               res.assign_note     = hit_key_ff;
               res.assign_velocity = voice_vel_ff[0];
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      poly_in       = csr_we ? csr_wdata : poly_ff;
      voice_note_in = voice_note_ff;
      voice_vel_in  = voice_vel_ff;
      key_held_in   = key_held_ff;
      op_in         = op_ff;
      note_in       = note_ff;
      vel_in        = vel_ff;
      vidx_in       = vidx_ff;
      grp_in        = grp_ff;
      match_in      = match_ff;
      free_in       = free_ff;
      match_idx_in  = match_idx_ff;
      free_idx_in   = free_idx_ff;
      mask_in       = mask_ff;
      hit_in        = hit_ff;
      hit_key_in    = hit_key_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (cmd.load) begin
         op_in    = req_op;
         note_in  = req_note;
         vel_in   = req_velocity;
         vidx_in  = '0;
         grp_in   = '1;
         match_in = 1'b0;
         free_in  = 1'b0;
         mask_in  = '0;
         hit_in   = 1'b0;
         case (req_op)
            OP_KEY_ON:  key_held_in[req_note] = 1'b1;
            OP_KEY_OFF: key_held_in[req_note] = 1'b0;
            OP_ALL_OFF: key_held_in = '0;
            default: begin
            end
         endcase
      end

      if (cmd.voice_step) begin
         if (!voice_last) vidx_in = vidx_ff + VIW'(1);
         case (op_ff)
            OP_KEY_ON: begin
               if (!match_ff && cur_match) begin
                  match_in     = 1'b1;
                  match_idx_in = vidx_ff;
               end
               if (!free_ff && cur_free) begin
                  free_in     = 1'b1;
                  free_idx_in = vidx_ff;
               end
            end
            OP_KEY_OFF: begin
               if (cur_match) begin
                  voice_note_in[vidx_ff] = VOICE_FREE;
                  mask_in = mask_ff | (MASK_W'(1) << vidx_ff);
               end
            end
            OP_ALL_OFF: begin
               if (!cur_free) mask_in = mask_ff | (MASK_W'(1) << vidx_ff);
               voice_note_in[vidx_ff] = VOICE_FREE;
            end
            default: begin
            end
         endcase
      end

      if (cmd.key_step) begin
         if (grp_hit) begin
            hit_in           = 1'b1;
            hit_key_in       = {grp_ff, hit_pos};
            voice_note_in[0] = {1'b0, grp_ff, hit_pos};
         end else begin
            grp_in = grp_ff - GRP_W'(1);
         end
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
         if (wr_en) begin
            voice_note_in[wr_idx] = {1'b0, note_ff};
            voice_vel_in[wr_idx]  = vel_ff;
         end
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff      <= POLY_RESET;
         key_held_ff  <= '0;
         op_ff        <= OP_NONE;
         rsp_valid_ff <= 1'b0;
         for (int v = 0; v < MAX_VOICES; v++) begin
            voice_note_ff[v] <= VOICE_FREE;
            voice_vel_ff[v]  <= '0;
         end
      end else begin
         poly_ff       <= poly_in;
         key_held_ff   <= key_held_in;
         op_ff         <= op_in;
         rsp_valid_ff  <= rsp_valid_in;
         voice_note_ff <= voice_note_in;
         voice_vel_ff  <= voice_vel_in;
      end
   end

   always_ff @(posedge clock) begin
      note_ff      <= note_in;
      vel_ff       <= vel_in;
      vidx_ff      <= vidx_in;
      grp_ff       <= grp_in;
      match_ff     <= match_in;
      free_ff      <= free_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      mask_ff      <= mask_in;
      hit_ff       <= hit_in;
      hit_key_ff   <= hit_key_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign stat.op         = op_ff;
   assign stat.mono       = mono;
   assign stat.voice_last = voice_last;
   assign stat.key_last   = (grp_ff == '0);
   assign stat.key_hit    = grp_hit;
   assign stat.out_free   = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/synth_voice_allocator.sv =====
// Channel  Dir  Handshake          Beat contents
// req_ch   in   valid/ready        mode, note, velocity
// rsp_ch   out  valid/ready        assign_*, restart_voice, jump_pitch, dropped, released_mask
// csr      in   csr_we (no wait)   csr_wdata = polyphony
//
// One request beat at a time: accept, decode, a check of each voice (polyphony
// voices on a poly key-on, MAX_VOICES on key-off and all-off, none otherwise), on a mono
// key-off up to 16 groups of 8 keys from the top, then the response load. The next
// request is taken while a response still waits for rsp_ch.ready; the load holds until
// the response register is free.
// reset is synchronous, active high: all voices free, key map clear, polyphony 8.
module synth_voice_allocator import svalloc_pkg::*; #(
   parameter int MAX_VOICES = 8
) (
   input  logic                clock,
   input  logic                reset,
   svalloc_req_if.sink         req_ch,
   svalloc_rsp_if.source       rsp_ch,
   input  logic                csr_we,
   input  logic [POLY_W-1:0]   csr_wdata
);

   cmd_type  cmd;
   stat_type stat;
   rsp_type  rsp_data;
   logic     rsp_valid;

   // sequencer: walks accept, voice scan, key search and response load
   svalloc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // voice table, held-key map, scan counters and the response register
   svalloc_dp #(
      .MAX_VOICES (MAX_VOICES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_mode     (req_ch.mode),
      .req_note     (req_ch.note),
      .req_velocity (req_ch.velocity),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

   // drive the response beat straight from the output register
   assign rsp_ch.valid           = rsp_valid;
   assign rsp_ch.assign_valid    = rsp_data.assign_valid;
   assign rsp_ch.assign_voice    = rsp_data.assign_voice;
   assign rsp_ch.assign_note     = rsp_data.assign_note;
   assign rsp_ch.assign_velocity = rsp_data.assign_velocity;
   assign rsp_ch.restart_voice   = rsp_data.restart_voice;
   assign rsp_ch.jump_pitch      = rsp_data.jump_pitch;
   assign rsp_ch.dropped         = rsp_data.dropped;
   assign rsp_ch.released_mask   = rsp_data.released_mask;

endmodule
